>>> rtl/ahwt_pkg.sv
package ahwt_pkg;

    localparam int MAX_LAYERS  = 8;
    localparam int MAX_REGIONS = 64;
    localparam int LAYER_W     = 3;
    localparam int REGION_W    = 6;
    localparam int ENTRY_W     = LAYER_W + REGION_W;
    localparam int ENTRIES     = MAX_LAYERS * MAX_REGIONS;

    localparam logic [0:0] CFG_LAYER_COUNT   = 1'b0;
    localparam logic [0:0] CFG_SPEED_CEILING = 1'b1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] ST_GREEN  = 2'd0;
    localparam logic [1:0] ST_WHITE  = 2'd1;
    localparam logic [1:0] ST_YELLOW = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  layer;
        logic [5:0]  region;
        logic [19:0] observed_rate;
        logic        jarring;
    } req_t;

    typedef struct packed {
        logic       ignored;
        logic [9:0] quality;
        logic [9:0] pressure;
        logic [9:0] press_peak;
        logic [9:0] qual_mean;
        logic [9:0] press_mean;
        logic [9:0] layer_health;
        logic [1:0] layer_state;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_DIV, S_CALC, S_JAR, S_HEALTH, S_OUT
    } state_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [9:0] eighth_step(input logic [9:0] avg, input logic [9:0] s);
        logic signed [11:0] d;
        logic signed [11:0] r;
        d = $signed({2'b00, s}) - $signed({2'b00, avg});
        r = $signed({2'b00, avg}) + (d >>> 3);
        return r[9:0];
    endfunction

endpackage

>>> rtl/ahwt_divider.sv
module ahwt_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [19:0] divisor,
    output logic        done,
    output logic [29:0] quotient
);
    import ahwt_pkg::*;

    logic [29:0] q_reg, q_next;
    logic [20:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [20:0] trial;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[19:0], q_reg[29]};
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = 5'd29;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
                q_next   = {q_reg[28:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[28:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done     = busy_reg && (cnt_reg == 5'd0);
    assign quotient = q_next;
endmodule

>>> rtl/access_health_wear_tracker_unit.sv
// Channel | Ports              | Payload
// request | s_valid / s_ready  | s_data (req_t)
// result  | m_valid / m_ready  | m_data (rsp_t)
// config  | cfg_we             | cfg_index, cfg_wdata
// After reset a clearing pass runs over all 512 entries of the region tables; no request is taken.
// A read with a non-zero ceiling goes from accept to result through a table read,
// 30 steps of the shared restoring divider, an update step and a health step.
// A write or a zero ceiling skips the divider.
// A jarring request adds a sweep over the active layers, one step per layer, before the health step.
// An ignored request answers on the next cycle; no request is taken while a result waits.
module access_health_wear_tracker_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ahwt_pkg::req_t      s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ahwt_pkg::rsp_t      m_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [19:0]         cfg_wdata
);
    import ahwt_pkg::*;

    logic [31:0] rd_mem [ENTRIES];
    logic [31:0] wr_mem [ENTRIES];
    logic [31:0] jr_mem [ENTRIES];
    logic [9:0]  pk_mem [ENTRIES];

    logic [31:0] lrd_reg [MAX_LAYERS];
    logic [31:0] lwr_reg [MAX_LAYERS];
    logic [31:0] ljr_reg [MAX_LAYERS];
    logic [9:0]  laq_reg [MAX_LAYERS];
    logic [9:0]  lap_reg [MAX_LAYERS];

    logic [3:0]  lcount_reg;
    logic [19:0] ceil_reg;

    state_t      state_reg, state_next;
    req_t        req_reg;
    rsp_t        rsp_reg, rsp_next;
    logic [ENTRY_W:0] ptr_reg, ptr_next;
    logic [31:0] rdq_reg, wrq_reg, jrq_reg;
    logic [9:0]  pkq_reg;
    logic [31:0] rd_new, wr_new, jr_new;
    logic [9:0]  pk_new;
    logic [9:0]  qual_reg, qual_next;
    logic [9:0]  pres_reg, pres_next;
    logic        mem_we;
    logic        mvalid_reg, mvalid_next;
    logic [3:0]  active;
    logic [ENTRY_W-1:0] addr;
    logic        div_start, div_done;
    logic [29:0] div_q;
    logic [31:0] wear_l, jar_l;
    logic [9:0]  health;

    ahwt_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({10'd0, req_reg.observed_rate} * 30'd1000),
        .divisor(ceil_reg), .done(div_done), .quotient(div_q)
    );

    assign active = (lcount_reg > 4'd8) ? 4'd8 : lcount_reg;
    assign addr   = (state_reg == S_CLEAR) ? ptr_reg[ENTRY_W-1:0]
                                           : {req_reg.layer, req_reg.region};
    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = rsp_reg;

    function automatic logic [9:0] pressure_of(input logic [31:0] c);
        logic [5:0] n;
        n = '0;
        for (int k = 0; k < 32; k++) begin
            if (c[k]) n = 6'(k + 1);
        end
        return (n >= 6'd20) ? 10'd1000 : 10'(n) * 10'd50;
    endfunction

    assign wear_l  = lwr_reg[req_reg.layer];
    assign jar_l   = ljr_reg[req_reg.layer];
    always_comb begin
        logic [32:0] p;
        p = {7'd0, wear_l[31:6]} + {3'd0, jar_l[31:2]};
        health = (p >= 33'd1000) ? 10'd0 : 10'(33'd1000 - p);
    end

    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        rsp_next    = rsp_reg;
        qual_next   = qual_reg;
        pres_next   = pres_reg;
        mvalid_next = mvalid_reg;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        rd_new = rdq_reg; wr_new = wrq_reg; jr_new = jrq_reg; pk_new = pkq_reg;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                rd_new = '0; wr_new = '0; jr_new = '0; pk_new = '0;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (ENTRY_W+1)'(ENTRIES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if ({1'b0, s_data.layer} >= active) begin
                        rsp_next = '0;
                        rsp_next.ignored = 1'b1;
                        mvalid_next = 1'b1;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                qual_next = '0;
                pres_next = '0;
                if (req_reg.cmd == CMD_READ && ceil_reg != '0) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_CALC;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    qual_next  = (div_q > 30'd1000) ? 10'd1000 : div_q[9:0];
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                mem_we = 1'b1;
                if (req_reg.cmd == CMD_READ) begin
                    rd_new = sat_inc(rdq_reg);
                    pres_next = pressure_of(rd_new);
                    if (pres_next > pkq_reg) pk_new = pres_next;
                end else begin
                    wr_new = sat_inc(wrq_reg);
                end
                if (req_reg.jarring) jr_new = sat_inc(jrq_reg);
                ptr_next = '0;
                state_next = req_reg.jarring ? S_JAR : S_HEALTH;
                rsp_next = '0;
                rsp_next.press_peak = pk_new;
            end
            S_JAR: begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg[3:0] == active - 4'd1) state_next = S_HEALTH;
            end
            S_HEALTH: begin
                rsp_next.quality      = (req_reg.cmd == CMD_READ) ? qual_reg : 10'd0;
                rsp_next.pressure     = (req_reg.cmd == CMD_READ) ? pres_reg : 10'd0;
                rsp_next.qual_mean    = laq_reg[req_reg.layer];
                rsp_next.press_mean   = lap_reg[req_reg.layer];
                rsp_next.layer_health = health;
                rsp_next.layer_state  = (health < 10'd600) ? ST_YELLOW :
                                        (health < 10'd850) ? ST_WHITE : ST_GREEN;
                mvalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            ptr_reg    <= '0;
            mvalid_reg <= 1'b0;
            lcount_reg <= 4'd1;
            ceil_reg   <= '0;
            for (int i = 0; i < MAX_LAYERS; i++) begin
                lrd_reg[i] <= '0; lwr_reg[i] <= '0; ljr_reg[i] <= '0;
                laq_reg[i] <= 10'd1000; lap_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_LAYER_COUNT) lcount_reg <= cfg_wdata[3:0];
                else ceil_reg <= cfg_wdata;
            end
            if (state_reg == S_CALC) begin
                if (req_reg.cmd == CMD_READ) begin
                    lrd_reg[req_reg.layer] <= sat_inc(lrd_reg[req_reg.layer]);
                    laq_reg[req_reg.layer] <= eighth_step(laq_reg[req_reg.layer], qual_reg);
                    lap_reg[req_reg.layer] <= eighth_step(lap_reg[req_reg.layer], pres_next);
                end else begin
                    lwr_reg[req_reg.layer] <= sat_inc(lwr_reg[req_reg.layer]);
                end
                if (req_reg.jarring)
                    ljr_reg[req_reg.layer] <= sat_inc(ljr_reg[req_reg.layer]);
            end
            if (state_reg == S_JAR)
                ljr_reg[ptr_reg[2:0]] <= sat_inc(ljr_reg[ptr_reg[2:0]]);
        end
        if (s_valid && s_ready) req_reg <= s_data;
        rsp_reg  <= rsp_next;
        qual_reg <= qual_next;
        pres_reg <= pres_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rd_mem[addr] <= rd_new;
            wr_mem[addr] <= wr_new;
            jr_mem[addr] <= jr_new;
            pk_mem[addr] <= pk_new;
        end
        rdq_reg <= rd_mem[addr];
        wrq_reg <= wr_mem[addr];
        jrq_reg <= jr_mem[addr];
        pkq_reg <= pk_mem[addr];
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !s_ready) else $error("double accept");
endmodule

>>> sim/access_health_wear_tracker_unit_tb.sv
module access_health_wear_tracker_unit_tb;
    import ahwt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsp_t        m_data;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [19:0] cfg_wdata = '0;

    int mismatches = 0;
    int send_idle = 0;
    int recv_stall = 0;
    logic jar_heavy = 1'b0;

    access_health_wear_tracker_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    class wear_scoreboard;
        logic [31:0] rd_cnt [ENTRIES];
        logic [31:0] wr_cnt [ENTRIES];
        logic [31:0] jar_cnt [ENTRIES];
        logic [9:0]  peak [ENTRIES];
        logic [31:0] reads [MAX_LAYERS];
        logic [31:0] wear [MAX_LAYERS];
        logic [31:0] jars [MAX_LAYERS];
        logic [9:0]  avg_q [MAX_LAYERS];
        logic [9:0]  avg_p [MAX_LAYERS];
        logic [3:0]  layers;
        logic [19:0] ceiling;
        rsp_t        pending [$];

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                rd_cnt[i] = '0; wr_cnt[i] = '0; jar_cnt[i] = '0; peak[i] = '0;
            end
            for (int i = 0; i < MAX_LAYERS; i++) begin
                reads[i] = '0; wear[i] = '0; jars[i] = '0;
                avg_q[i] = 10'd1000; avg_p[i] = '0;
            end
            layers = 4'd1;
            ceiling = '0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function logic [9:0] ease(logic [9:0] a, logic [9:0] s);
            if (s >= a) return a + ((s - a) >> 3);
            return a - ((a - s + 10'd7) >> 3);
        endfunction

        function void note_request(req_t q);
            rsp_t r;
            int act, e, p, health;
            longint qq;
            logic [31:0] c, pen;
            r = '0;
            act = (layers > MAX_LAYERS) ? MAX_LAYERS : int'(layers);
            if (q.layer >= act) begin
                r.ignored = 1'b1;
                pending.push_back(r);
                return;
            end
            e = q.layer * MAX_REGIONS + q.region;
            if (q.cmd == CMD_READ) begin
                rd_cnt[e] = bump(rd_cnt[e]);
                reads[q.layer] = bump(reads[q.layer]);
                if (ceiling == 0) qq = 0;
                else qq = (longint'(q.observed_rate) * 1000) / ceiling;
                if (qq > 1000) qq = 1000;
                p = 0;
                c = rd_cnt[e];
                while (c != 0 && p < 1000) begin
                    p += 50;
                    c >>= 1;
                end
                if (p > peak[e]) peak[e] = 10'(p);
                avg_q[q.layer] = ease(avg_q[q.layer], 10'(qq));
                avg_p[q.layer] = ease(avg_p[q.layer], 10'(p));
                r.quality = 10'(qq);
                r.pressure = 10'(p);
            end else begin
                wr_cnt[e] = bump(wr_cnt[e]);
                wear[q.layer] = bump(wear[q.layer]);
            end
            if (q.jarring) begin
                jar_cnt[e] = bump(jar_cnt[e]);
                jars[q.layer] = bump(jars[q.layer]);
                for (int i = 0; i < act; i++) jars[i] = bump(jars[i]);
            end
            pen = (wear[q.layer] >> 6) + (jars[q.layer] >> 2);
            health = (pen >= 32'd1000) ? 0 : 1000 - int'(pen);
            r.press_peak = peak[e];
            r.qual_mean = avg_q[q.layer];
            r.press_mean = avg_p[q.layer];
            r.layer_health = 10'(health);
            r.layer_state = (health < 600) ? ST_YELLOW : (health < 850) ? ST_WHITE : ST_GREEN;
            pending.push_back(r);
        endfunction

        task check_result(rsp_t got);
            rsp_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.ignored !== w.ignored) report_mismatch("ignored", got.ignored, w.ignored);
            if (got.quality !== w.quality) report_mismatch("quality", got.quality, w.quality);
            if (got.pressure !== w.pressure)
                report_mismatch("pressure", got.pressure, w.pressure);
            if (got.press_peak !== w.press_peak)
                report_mismatch("press_peak", got.press_peak, w.press_peak);
            if (got.qual_mean !== w.qual_mean)
                report_mismatch("qual_mean", got.qual_mean, w.qual_mean);
            if (got.press_mean !== w.press_mean)
                report_mismatch("press_mean", got.press_mean, w.press_mean);
            if (got.layer_health !== w.layer_health)
                report_mismatch("layer_health", got.layer_health, w.layer_health);
            if (got.layer_state !== w.layer_state)
                report_mismatch("layer_state", got.layer_state, w.layer_state);
        endtask
    endclass

    wear_scoreboard health_board = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) health_board.note_request(s_data);
            if (m_valid && m_ready) health_board.check_result(m_data);
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_LAYER_COUNT) health_board.layers = val[3:0];
        else health_board.ceiling = val;
    endtask

    task automatic send_request(input req_t q);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        req_t q;
        q.cmd = 1'($urandom_range(1));
        q.layer = 3'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3));
        q.region = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3));
        case ($urandom_range(3))
            0: q.observed_rate = 20'($urandom_range(20'hFFFFF));
            1: q.observed_rate = health_board.ceiling;
            2: q.observed_rate = 20'hFFFFF;
            default: q.observed_rate = 20'($urandom_range(2000));
        endcase
        q.jarring = jar_heavy ? ($urandom_range(3) != 0) : ($urandom_range(7) == 0);
        send_request(q);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (health_board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        req_t q;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(CFG_SPEED_CEILING, 20'd1000);
        write_reg(CFG_LAYER_COUNT, 20'd8);
        for (int i = 0; i < 20; i++) begin
            q.cmd = i[0];
            q.layer = 3'((i < 8) ? i : 7 * (i & 1));
            q.region = (i & 2) ? 6'd63 : 6'd0;
            q.observed_rate = (i & 4) ? 20'hFFFFF : ((i & 8) ? 20'd0 : 20'd500);
            q.jarring = i[1];
            send_request(q);
        end
        drain();
        write_reg(CFG_SPEED_CEILING, 20'd0);
        write_reg(CFG_LAYER_COUNT, 20'd0);
        q = '{cmd: CMD_READ, layer: 3'd0, region: 6'd1, observed_rate: 20'd7, jarring: 1'b1};
        send_request(q);
        drain();
        write_reg(CFG_LAYER_COUNT, 20'd15);
        send_request(q);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            jar_heavy = (ph == 4);
            write_reg(CFG_LAYER_COUNT, (ph == 5) ? 20'd1 : 20'($urandom_range(8, 1)));
            write_reg(CFG_SPEED_CEILING,
                      (ph == 3) ? 20'hFFFFF : (ph == 5) ? 20'd1 : 20'($urandom_range(20'hFFFFF)));
            repeat (200) send_random();
            drain();
        end
        if (mismatches == 0)
            $display("access_health_wear_tracker_unit_tb: clean");
        else
            $display("access_health_wear_tracker_unit_tb: errors");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("access_health_wear_tracker_unit_tb: errors");
        $finish;
    end
endmodule

>>> access_health_wear_tracker_unit.f
rtl/ahwt_pkg.sv
rtl/ahwt_divider.sv
rtl/access_health_wear_tracker_unit.sv
sim/access_health_wear_tracker_unit_tb.sv
